/* hw/rtl/trfp_pkg.sv */
// trfp_pkg: shared types and constants of the touch report frame parser
// no dependencies; used by trfp_core and the top level
`timescale 1ns / 1ps

package trfp_pkg;

    // default frame geometry
    localparam int FRAME_BYTES_DEF = 26;
    localparam int MAX_POINTS_DEF  = 5;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 12;
    localparam int ID_W    = 4;
    localparam int EVT_W   = 2;

    // frame layout
    localparam logic [BYTE_W-1:0] HDR_MARK = 8'haa;
    localparam int                REC_BASE = 5;

    // result kind codes
    typedef enum logic {
        KIND_POINT     = 1'b0,
        KIND_FRAME_END = 1'b1
    } t_kind;

    // one input item
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_start;
    } t_in_item;

    // one result item
    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [ID_W-1:0]    track_id;
        logic [EVT_W-1:0]   event_kind;
        logic               primary;
        logic               touch_down;
        logic               header_bad;
    } t_out_item;

    // result of decoding one byte
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res;

endpackage

/* hw/rtl/trfp_stream_if.sv */
// trfp_stream_if: valid/ready channel carrying one item of payload type T
// depends on nothing; payload types come from trfp_pkg at the instance
`timescale 1ns / 1ps

interface trfp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/trfp_core.sv */
// trfp_core: frame position tracking, header check and record decode
// depends on trfp_pkg; one byte is consumed per cycle in which i_step is high
`timescale 1ns / 1ps

module trfp_core #(
    parameter int FRAME_BYTES = trfp_pkg::FRAME_BYTES_DEF,
    parameter int MAX_POINTS  = trfp_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  trfp_pkg::t_in_item                i_item,
    output trfp_pkg::t_res                    o_res
);
    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CAP   = (FRAME_BYTES - 6) / 4;
    localparam int LIM   = (MAX_POINTS < CAP) ? MAX_POINTS : CAP;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_REC  = POS_W'(trfp_pkg::REC_BASE);
    localparam logic [POS_W-1:0] POS_CNT  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LEN  = POS_W'(2);
    localparam logic [7:0]       LEN_BYTE = 8'(FRAME_BYTES);
    localparam logic [7:0]       LIM_BYTE = 8'(LIM);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_reported, n_reported;
    logic             r_hdr_err, n_hdr_err;
    logic [7:0]       r_rec [3];

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] rel;
    logic [1:0]       off;
    logic [POS_W-1:0] rec;
    logic             first;
    logic             rec_wr;
    logic [7:0]       b;
    logic [CNT_W-1:0] cnt_base;
    logic             rep_base;
    logic             err_base;
    trfp_pkg::t_res   res;

    // position of this byte and per-frame state as seen by it
    always_comb begin
        b        = i_item.data_byte;
        pos      = i_item.frame_start ? '0 : r_pos;
        first    = (pos == '0);
        cnt_base = first ? '0 : r_cnt;
        rep_base = first ? 1'b0 : r_reported;
        err_base = first ? 1'b0 : r_hdr_err;
        rel      = pos - POS_REC;
        off      = rel[1:0];
        rec      = rel >> 2;
    end

    // byte decode: next state and result
    always_comb begin
        n_pos      = pos + POS_W'(1);
        n_cnt      = cnt_base;
        n_reported = rep_base;
        n_hdr_err  = err_base;
        rec_wr     = 1'b0;
        res        = '0;
        if (pos == POS_LAST) begin
            // frame end sync
            n_pos                = '0;
            res.valid            = 1'b1;
            res.item.kind        = trfp_pkg::KIND_FRAME_END;
            res.item.touch_down  = rep_base;
            res.item.header_bad  = err_base;
        end else if (pos < POS_LEN) begin
            if (b != trfp_pkg::HDR_MARK) begin
                n_hdr_err = 1'b1;
            end
        end else if (pos == POS_LEN) begin
            if (b != LEN_BYTE) begin
                n_hdr_err = 1'b1;
            end
        end else if (pos == POS_CNT) begin
            // touch count, held at MAX_POINTS or what the frame can carry, if smaller
            n_cnt = (b > LIM_BYTE) ? CNT_W'(LIM) : b[CNT_W-1:0];
        end else if (pos >= POS_REC) begin
            if (off != 2'd3) begin
                rec_wr = 1'b1;
            end else if ((rec < POS_W'(cnt_base)) && !r_rec[0][6]) begin
                // event types 0 and 2 are reported, 1 and 3 skipped
                res.valid           = 1'b1;
                res.item.kind       = trfp_pkg::KIND_POINT;
                res.item.pos_x      = {r_rec[0][3:0], r_rec[1]};
                res.item.pos_y      = {r_rec[2][3:0], b};
                res.item.track_id   = r_rec[2][7:4];
                res.item.event_kind = r_rec[0][7:6];
                res.item.primary    = !rep_base;
                n_reported          = 1'b1;
            end
        end
    end

    assign o_res = res;

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_cnt      <= '0;
            r_reported <= 1'b0;
            r_hdr_err  <= 1'b0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_cnt      <= n_cnt;
            r_reported <= n_reported;
            r_hdr_err  <= n_hdr_err;
        end
    end

    // first three bytes of the current record
    always_ff @(posedge i_clk) begin
        if (i_step && rec_wr) begin
            r_rec[off] <= b;
        end
    end

    // checks
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("byte position past frame end");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(LIM))
        else $error("touch count above limit");

    a_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.valid && res.item.kind == trfp_pkg::KIND_FRAME_END)
        |=> (r_pos == '0))
        else $error("position did not wrap after frame end");

    a_primary_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.valid && res.item.kind == trfp_pkg::KIND_POINT)
        |=> r_reported)
        else $error("reported flag not set after a point");

endmodule

/* hw/rtl/touch_report_frame_parser.sv */
// touch_report_frame_parser: top level, input and result registers around trfp_core
// depends on trfp_pkg, trfp_stream_if and trfp_core
//
// Usage:
//   i_in carries one frame byte per item (data_byte, frame_start); o_out
//   carries at most one result item per byte: a touch point on the fourth
//   byte of each reported record, and a frame-end item on the last byte.
//   Setting frame_start forces the byte to be taken as byte 0; after the
//   last byte the position wraps so the next byte starts a new frame.
// Path: an accepted byte is held in the input register; its result is loaded
//   into the result register when the decode steps on it, which a stall delays.
// Throughput: one byte per cycle while not stalled; the decode is a single pass
//   of position compares and field slicing between the two registers.
// Stall: while a result waits on o_out, one more byte is taken into the
//   input register; bytes that produce no result keep flowing through the
//   decode, and i_in.ready drops only when the next byte would need the
//   occupied result register.
// Reset: i_rst_n (synchronous, active low) empties both registers and sets
//   the position, touch count and frame flags to zero.
`timescale 1ns / 1ps

module touch_report_frame_parser #(
    parameter int FRAME_BYTES = trfp_pkg::FRAME_BYTES_DEF,
    parameter int MAX_POINTS  = trfp_pkg::MAX_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    trfp_stream_if.sink          i_in,
    trfp_stream_if.source        o_out
);
    logic                r_in_valid;
    trfp_pkg::t_in_item  r_in;
    logic                r_out_valid;
    trfp_pkg::t_out_item r_out;
    logic                step;
    trfp_pkg::t_res      res;

    // decode advances on a held byte unless its result would overwrite a waiting one
    assign step        = r_in_valid && (!r_out_valid || o_out.ready || !res.valid);
    assign i_in.ready  = !r_in_valid || step;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    trfp_core #(
        .FRAME_BYTES (FRAME_BYTES),
        .MAX_POINTS  (MAX_POINTS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_out <= res.item;
        end
    end

endmodule
